// ===== sv/jcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// jcsc_pkg
// Shared types and codes for the Japanese charset stream converter.
// ----------------------------------------------------------------------------
package jcsc_pkg;

  // Conversion mode register codes
  localparam logic [2:0] MODE_JIS_SJIS = 3'd0;
  localparam logic [2:0] MODE_JIS_EUC  = 3'd1;
  localparam logic [2:0] MODE_SJIS_JIS = 3'd2;
  localparam logic [2:0] MODE_EUC_JIS  = 3'd3;
  localparam logic [2:0] MODE_EUC_SJIS = 3'd4;
  localparam logic [2:0] MODE_SJIS_EUC = 3'd5;

  // Longest output burst caused by one source byte (ESC $ @ c1 c2)
  localparam int unsigned MaxBurst = 5;
  localparam int unsigned CntW     = $clog2(MaxBurst + 1);

  // Byte codes
  localparam logic [7:0] ESC_CHAR    = 8'h1b;
  localparam logic [7:0] DOLLAR_CODE = 8'h24;  // '$'
  localparam logic [7:0] AT_CODE     = 8'h40;  // '@'
  localparam logic [7:0] LPAREN_CODE = 8'h28;  // '('
  localparam logic [7:0] J_CODE      = 8'h4a;  // 'J'
  localparam logic [7:0] G0_LO       = 8'h21;
  localparam logic [7:0] G0_HI       = 8'h7e;

  // Converter state carried from byte to byte
  typedef struct packed {
    logic       two_byte_mode;
    logic       escape_held;
    logic       skip_next_byte;
    logic       lead_held;
    logic [7:0] lead_value;
  } conv_state_t;

  // Output bytes of one source byte, element 0 goes out first
  typedef struct packed {
    logic [MaxBurst-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
  } burst_t;

endpackage

// ===== sv/jcsc_decode.sv =====
// ----------------------------------------------------------------------------
// jcsc_decode
// Per-byte conversion logic: next state and the output burst of one byte.
// ----------------------------------------------------------------------------
module jcsc_decode (
  input  logic [7:0]           byte_in,
  input  logic [2:0]           mode,
  input  jcsc_pkg::conv_state_t st,
  output jcsc_pkg::conv_state_t st_nxt,
  output jcsc_pkg::burst_t      burst
);

  // JIS pair to Shift-JIS pair, {s1, s2}
  function automatic logic [15:0] jis2sjis(input logic [7:0] j1, input logic [7:0] j2);
    logic [8:0] h;
    logic [7:0] s1;
    logic [7:0] s2;
    h  = {1'b0, j1} + 9'd1;
    s1 = h[8:1] + ((j1 <= 8'h5e) ? 8'h70 : 8'hb0);
    if (j1[0]) begin
      s2 = j2 + ((j2 >= 8'h60) ? 8'h20 : 8'h1f);
    end else begin
      s2 = j2 + 8'h7e;
    end
    return {s1, s2};
  endfunction

  // Shift-JIS pair to JIS pair, {j1, j2}
  function automatic logic [15:0] sjis2jis(input logic [7:0] s1, input logic [7:0] s2);
    logic [7:0] a;
    logic [7:0] j2;
    a = (s1 <= 8'h9f) ? (s1 - 8'h71) : (s1 - 8'hb1);
    a = {a[6:0], 1'b1};
    if (s2 >= 8'h9f) begin
      a  = a + 8'd1;
      j2 = s2 - 8'h7e;
    end else begin
      j2 = s2 - ((s2 >= 8'h80) ? 8'h20 : 8'h1f);
    end
    return {a, j2};
  endfunction

  logic [15:0] pair;
  logic [15:0] sj;
  logic [15:0] js;
  logic        in_g0;

  // Pair conversion for the selected direction
  always_comb begin
    sj = jis2sjis(st.lead_value & 8'h7f, byte_in & 8'h7f);
    js = sjis2jis(st.lead_value, byte_in);
    unique case (mode)
      jcsc_pkg::MODE_JIS_SJIS: pair = jis2sjis(st.lead_value, byte_in);
      jcsc_pkg::MODE_JIS_EUC:  pair = {st.lead_value | 8'h80, byte_in | 8'h80};
      jcsc_pkg::MODE_SJIS_JIS: pair = js;
      jcsc_pkg::MODE_EUC_JIS:  pair = {st.lead_value & 8'h7f, byte_in & 8'h7f};
      jcsc_pkg::MODE_EUC_SJIS: pair = sj;
      default:                 pair = js | 16'h8080;
    endcase
  end

  assign in_g0 = (byte_in >= jcsc_pkg::G0_LO) && (byte_in <= jcsc_pkg::G0_HI);

  // State update and burst build
  always_comb begin
    st_nxt       = st;
    burst.bytes  = '0;
    burst.count  = '0;
    unique case (mode)
      jcsc_pkg::MODE_JIS_SJIS, jcsc_pkg::MODE_JIS_EUC: begin
        if (st.skip_next_byte) begin
          st_nxt.skip_next_byte = 1'b0;
        end else if (st.escape_held) begin
          st_nxt.escape_held = 1'b0;
          if (st.two_byte_mode && byte_in == jcsc_pkg::LPAREN_CODE) begin
            st_nxt.skip_next_byte = 1'b1;
            st_nxt.two_byte_mode  = 1'b0;
          end else if (!st.two_byte_mode && byte_in == jcsc_pkg::DOLLAR_CODE) begin
            st_nxt.skip_next_byte = 1'b1;
            st_nxt.two_byte_mode  = 1'b1;
          end else begin
            // unknown escape: send ESC, then treat this byte as fresh
            burst.bytes[0] = jcsc_pkg::ESC_CHAR;
            burst.count    = 3'd1;
            if (byte_in == jcsc_pkg::ESC_CHAR) begin
              st_nxt.escape_held = 1'b1;
            end else if (st.two_byte_mode && in_g0) begin
              st_nxt.lead_held  = 1'b1;
              st_nxt.lead_value = byte_in;
            end else begin
              burst.bytes[1] = byte_in;
              burst.count    = 3'd2;
            end
          end
        end else if (st.lead_held) begin
          st_nxt.lead_held = 1'b0;
          burst.bytes[0]   = pair[15:8];
          burst.bytes[1]   = pair[7:0];
          burst.count      = 3'd2;
        end else if (byte_in == jcsc_pkg::ESC_CHAR) begin
          st_nxt.escape_held = 1'b1;
        end else if (st.two_byte_mode && in_g0) begin
          st_nxt.lead_held  = 1'b1;
          st_nxt.lead_value = byte_in;
        end else begin
          burst.bytes[0] = byte_in;
          burst.count    = 3'd1;
        end
      end
      jcsc_pkg::MODE_SJIS_JIS, jcsc_pkg::MODE_EUC_JIS: begin
        if (st.lead_held) begin
          st_nxt.lead_held = 1'b0;
          if (!st.two_byte_mode) begin
            // enter kanji mode first: ESC $ @
            st_nxt.two_byte_mode = 1'b1;
            burst.bytes[0] = jcsc_pkg::ESC_CHAR;
            burst.bytes[1] = jcsc_pkg::DOLLAR_CODE;
            burst.bytes[2] = jcsc_pkg::AT_CODE;
            burst.bytes[3] = pair[15:8];
            burst.bytes[4] = pair[7:0];
            burst.count    = 3'd5;
          end else begin
            burst.bytes[0] = pair[15:8];
            burst.bytes[1] = pair[7:0];
            burst.count    = 3'd2;
          end
        end else if (byte_in[7]) begin
          st_nxt.lead_held  = 1'b1;
          st_nxt.lead_value = byte_in;
        end else if (st.two_byte_mode) begin
          // back to roman: ESC ( J
          st_nxt.two_byte_mode = 1'b0;
          burst.bytes[0] = jcsc_pkg::ESC_CHAR;
          burst.bytes[1] = jcsc_pkg::LPAREN_CODE;
          burst.bytes[2] = jcsc_pkg::J_CODE;
          burst.bytes[3] = byte_in;
          burst.count    = 3'd4;
        end else begin
          burst.bytes[0] = byte_in;
          burst.count    = 3'd1;
        end
      end
      jcsc_pkg::MODE_EUC_SJIS, jcsc_pkg::MODE_SJIS_EUC: begin
        if (st.lead_held) begin
          st_nxt.lead_held = 1'b0;
          burst.bytes[0]   = pair[15:8];
          burst.bytes[1]   = pair[7:0];
          burst.count      = 3'd2;
        end else if (byte_in[7]) begin
          st_nxt.lead_held  = 1'b1;
          st_nxt.lead_value = byte_in;
        end else begin
          burst.bytes[0] = byte_in;
          burst.count    = 3'd1;
        end
      end
      default: begin
        // unused modes pass the byte through
        burst.bytes[0] = byte_in;
        burst.count    = 3'd1;
      end
    endcase
  end

endmodule

// ===== sv/jcsc_burst.sv =====
// ----------------------------------------------------------------------------
// jcsc_burst
// Result register: holds one burst and shifts it out a byte per request.
// ----------------------------------------------------------------------------
module jcsc_burst (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  jcsc_pkg::burst_t burst,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  logic [jcsc_pkg::MaxBurst-1:0][7:0] buf_r, buf_nxt;
  logic [jcsc_pkg::CntW-1:0]          rem_r, rem_nxt;
  logic                               take;

  assign out_valid = (rem_r != '0);
  assign out_byte  = buf_r[0];
  assign out_last  = (rem_r == jcsc_pkg::CntW'(1));
  assign take      = out_valid && !out_stall;
  // empty, or the final byte leaves this cycle
  assign free      = !out_valid || (out_last && !out_stall);

  // Load or shift
  always_comb begin
    buf_nxt = buf_r;
    rem_nxt = rem_r;
    if (load) begin
      buf_nxt = burst.bytes;
      rem_nxt = burst.count;
    end else if (take) begin
      buf_nxt = buf_r >> 8;
      rem_nxt = rem_r - jcsc_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== sv/japanese_charset_stream_converter.sv =====
// ----------------------------------------------------------------------------
// japanese_charset_stream_converter
// JIS / EUC / Shift-JIS byte stream converter, direction set by a mode register.
// ----------------------------------------------------------------------------
//  channel | ports                                   | dir
//  --------+-----------------------------------------+-----
//  source  | in_valid, in_stall, in_byte             | in
//  result  | out_valid, out_stall, out_byte,         | out
//          | out_last_of_run                         |
//  config  | cfg_wr_en, cfg_wr_data                  | in
//
//  A source byte is registered, decoded in one pass and its burst of 0 to 5
//  bytes loaded into the result register; one source byte per cycle when each
//  byte gives at most one result and out_stall stays low. The result register,
//  one byte per cycle while out_stall is low, sets the rate: a burst holds the
//  source side until its last byte leaves. An accepted byte goes through the
//  input register and then the result register. rst_n clears the mode,
//  converter state and both valid flags. A stalled result holds its byte; the
//  source side stalls once the input register is full and the burst cannot move.
// ----------------------------------------------------------------------------
module japanese_charset_stream_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);

  logic                  in_v_r, in_v_nxt;
  logic [7:0]            in_byte_r;
  logic [2:0]            mode_r;
  jcsc_pkg::conv_state_t st_r, st_nxt, st_dec;
  jcsc_pkg::burst_t      burst;
  logic                  free;
  logic                  load;
  logic                  accept;

  // Input register handshake
  assign load     = in_v_r && free;
  assign in_stall = in_v_r && !free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (load) begin
      in_v_nxt = 1'b0;
    end
  end

  assign st_nxt = load ? st_dec : st_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_byte;
    end
    if (!rst_n) begin
      in_v_r <= 1'b0;
      mode_r <= jcsc_pkg::MODE_JIS_SJIS;
      st_r   <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      st_r   <= st_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  // Decode one byte
  jcsc_decode u_decode (
    .byte_in (in_byte_r),
    .mode    (mode_r),
    .st      (st_r),
    .st_nxt  (st_dec),
    .burst   (burst)
  );

  // Result register
  jcsc_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .burst     (burst),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last_of_run)
  );

  // Checks
  a_esc_skip_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.escape_held && st_r.skip_next_byte))
    else $error("escape and skip pending together");

  a_held_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !free |=> in_v_r && $stable(in_byte_r))
    else $error("held source byte lost");

  a_state_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(st_r))
    else $error("state changed without a decoded byte");

endmodule

// ===== verif/tb_japanese_charset_stream_converter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_japanese_charset_stream_converter
// Self-checking bench for the JIS / EUC / Shift-JIS stream converter.
// ----------------------------------------------------------------------------
// The byte source is a clocked driver that feeds requests from a queue that
// the stimulus block fills. A behavioral converter predicts the output bytes
// of each accepted source byte, and a clocked monitor checks every result
// request in order. Runs a short directed list, then random escape sequences,
// pairs and noise in every mode value, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb_japanese_charset_stream_converter;

  // Mode values with no conversion: bytes pass through
  localparam logic [2:0] MODE_PASS_6 = 3'd6;
  localparam logic [2:0] MODE_PASS_7 = 3'd7;
  localparam logic [7:0] ASCII_B     = 8'h42;
  localparam int         SETTLE_CYC  = 6;
  localparam int         PHASE_BYTES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_req_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last_of_run;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;

  // Source bytes waiting to go out, converted bytes still owed by the block
  logic [7:0]  src_bytes_q[$];
  out_req_t    owed_bytes_q[$];

  // Predictor copy of the register and converter state
  logic [2:0]            cnv_mode;
  jcsc_pkg::conv_state_t cnv_st;

  int   src_gap;
  int   snk_gap;
  bit   quiet;
  int   err_cnt;
  int   sent_cnt;
  int   recv_cnt;
  logic [2:0] phase_modes [9];

  japanese_charset_stream_converter uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void flag_error(input string what);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endfunction

  // Published JIS -> Shift-JIS pair formula
  function automatic logic [15:0] jis_pair_to_sjis(input logic [7:0] j1, input logic [7:0] j2);
    int unsigned hi, lo;
    hi = ((j1 + 32'd1) >> 1) + ((j1 <= 8'h5e) ? 32'h70 : 32'hb0);
    if (j1[0]) begin
      lo = j2 + ((j2 >= 8'h60) ? 32'h20 : 32'h1f);
    end else begin
      lo = j2 + 32'h7e;
    end
    return {hi[7:0], lo[7:0]};
  endfunction

  // Published Shift-JIS -> JIS pair formula, wraps to 8 bits
  function automatic logic [15:0] sjis_pair_to_jis(input logic [7:0] s1, input logic [7:0] s2);
    int unsigned hi, lo;
    hi = (s1 <= 8'h9f) ? s1 - 32'h71 : s1 - 32'hb1;
    hi = hi * 2 + 1;
    if (s2 >= 8'h9f) begin
      hi = hi + 1;
      lo = s2 - 32'h7e;
    end else begin
      lo = s2 - ((s2 >= 8'h80) ? 32'h20 : 32'h1f);
    end
    return {hi[7:0], lo[7:0]};
  endfunction

  function automatic logic [15:0] pair_convert(input logic [2:0] m, input logic [7:0] a,
                                               input logic [7:0] b);
    case (m)
      jcsc_pkg::MODE_JIS_SJIS: return jis_pair_to_sjis(a, b);
      jcsc_pkg::MODE_JIS_EUC:  return {a | 8'h80, b | 8'h80};
      jcsc_pkg::MODE_SJIS_JIS: return sjis_pair_to_jis(a, b);
      jcsc_pkg::MODE_EUC_JIS:  return {a & 8'h7f, b & 8'h7f};
      jcsc_pkg::MODE_EUC_SJIS: return jis_pair_to_sjis(a & 8'h7f, b & 8'h7f);
      default:                 return sjis_pair_to_jis(a, b) | 16'h8080;
    endcase
  endfunction

  // Convert one source byte and queue the bytes it owes
  task automatic predict_bytes(input logic [7:0] b);
    logic [7:0]  burst [jcsc_pkg::MaxBurst];
    logic [15:0] pr;
    int          n;
    logic        fresh;
    n     = 0;
    fresh = 1'b0;
    if (cnv_mode <= jcsc_pkg::MODE_JIS_EUC) begin
      // JIS source: escapes switch the kanji state
      if (cnv_st.skip_next_byte) begin
        cnv_st.skip_next_byte = 1'b0;
      end else if (cnv_st.escape_held) begin
        cnv_st.escape_held = 1'b0;
        if (cnv_st.two_byte_mode && b == jcsc_pkg::LPAREN_CODE) begin
          cnv_st.skip_next_byte = 1'b1;
          cnv_st.two_byte_mode  = 1'b0;
        end else if (!cnv_st.two_byte_mode && b == jcsc_pkg::DOLLAR_CODE) begin
          cnv_st.skip_next_byte = 1'b1;
          cnv_st.two_byte_mode  = 1'b1;
        end else begin
          // unknown escape: ESC goes out, byte taken as fresh
          burst[0] = jcsc_pkg::ESC_CHAR;
          n        = 1;
          fresh    = 1'b1;
        end
      end else if (cnv_st.lead_held) begin
        cnv_st.lead_held = 1'b0;
        pr       = pair_convert(cnv_mode, cnv_st.lead_value, b);
        burst[0] = pr[15:8];
        burst[1] = pr[7:0];
        n        = 2;
      end else begin
        fresh = 1'b1;
      end
      if (fresh) begin
        if (b == jcsc_pkg::ESC_CHAR) begin
          cnv_st.escape_held = 1'b1;
        end else if (cnv_st.two_byte_mode && b >= jcsc_pkg::G0_LO &&
                     b <= jcsc_pkg::G0_HI) begin
          cnv_st.lead_held  = 1'b1;
          cnv_st.lead_value = b;
        end else begin
          burst[n] = b;
          n        = n + 1;
        end
      end
    end else if (cnv_mode <= jcsc_pkg::MODE_EUC_JIS) begin
      // JIS target: shift sequences around kanji runs
      if (cnv_st.lead_held) begin
        cnv_st.lead_held = 1'b0;
        pr = pair_convert(cnv_mode, cnv_st.lead_value, b);
        if (!cnv_st.two_byte_mode) begin
          burst[0] = jcsc_pkg::ESC_CHAR;
          burst[1] = jcsc_pkg::DOLLAR_CODE;
          burst[2] = jcsc_pkg::AT_CODE;
          n        = 3;
          cnv_st.two_byte_mode = 1'b1;
        end
        burst[n]     = pr[15:8];
        burst[n + 1] = pr[7:0];
        n            = n + 2;
      end else if (b[7]) begin
        cnv_st.lead_held  = 1'b1;
        cnv_st.lead_value = b;
      end else if (cnv_st.two_byte_mode) begin
        burst[0] = jcsc_pkg::ESC_CHAR;
        burst[1] = jcsc_pkg::LPAREN_CODE;
        burst[2] = jcsc_pkg::J_CODE;
        burst[3] = b;
        n        = 4;
        cnv_st.two_byte_mode = 1'b0;
      end else begin
        burst[0] = b;
        n        = 1;
      end
    end else if (cnv_mode <= jcsc_pkg::MODE_SJIS_EUC) begin
      // EUC <-> Shift-JIS
      if (cnv_st.lead_held) begin
        cnv_st.lead_held = 1'b0;
        pr       = pair_convert(cnv_mode, cnv_st.lead_value, b);
        burst[0] = pr[15:8];
        burst[1] = pr[7:0];
        n        = 2;
      end else if (b[7]) begin
        cnv_st.lead_held  = 1'b1;
        cnv_st.lead_value = b;
      end else begin
        burst[0] = b;
        n        = 1;
      end
    end else begin
      burst[0] = b;
      n        = 1;
    end
    for (int i = 0; i < n; i++) begin
      owed_bytes_q.push_back('{data: burst[i], last: (i == n - 1)});
    end
  endtask

  // Source driver
  always @(posedge clk) begin : src_drv
    logic free;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      free = !in_valid;
      if (in_valid && !in_stall) begin
        predict_bytes(in_byte);
        sent_cnt++;
        free = 1'b1;
        if (!quiet && $urandom_range(0, 6) == 0) begin
          src_gap = $urandom_range(1, 10);
        end
      end
      if (free) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (src_bytes_q.size() != 0) begin
          in_valid <= 1'b1;
          in_byte  <= src_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and sink stall
  always @(posedge clk) begin : res_mon
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      recv_cnt++;
      if (owed_bytes_q.size() == 0) begin
        flag_error($sformatf("unexpected result byte %02h last %0b",
                             out_byte, out_last_of_run));
      end else begin
        want = owed_bytes_q.pop_front();
        if (out_byte !== want.data || out_last_of_run !== want.last) begin
          flag_error($sformatf("result %0d: exp byte %02h last %0b, got byte %02h last %0b",
                               recv_cnt, want.data, want.last, out_byte, out_last_of_run));
        end
      end
    end
    if (snk_gap > 0) begin
      snk_gap--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      snk_gap = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Wait for the source to drain and every owed byte to arrive, then let
  // a held lead byte or escape settle inside the block
  task automatic drain_and_settle();
    while (src_bytes_q.size() != 0 || in_valid || owed_bytes_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_mode(input logic [2:0] m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cnv_mode = m;
  endtask

  // One well-formed fragment, or noise, for the given mode
  task automatic queue_fragment(input logic [2:0] m, inout int n);
    int sel;
    sel = $urandom_range(0, 9);
    if (m <= jcsc_pkg::MODE_JIS_EUC) begin
      case (sel)
        0: begin
          src_bytes_q.push_back(jcsc_pkg::ESC_CHAR);
          src_bytes_q.push_back(jcsc_pkg::DOLLAR_CODE);
          src_bytes_q.push_back($urandom_range(0, 1) ? ASCII_B : jcsc_pkg::AT_CODE);
          n += 3;
        end
        1: begin
          src_bytes_q.push_back(jcsc_pkg::ESC_CHAR);
          src_bytes_q.push_back(jcsc_pkg::LPAREN_CODE);
          src_bytes_q.push_back($urandom_range(0, 1) ? ASCII_B : jcsc_pkg::J_CODE);
          n += 3;
        end
        2, 3, 4, 5: begin
          src_bytes_q.push_back(8'($urandom_range(jcsc_pkg::G0_LO, jcsc_pkg::G0_HI)));
          src_bytes_q.push_back(8'($urandom_range(jcsc_pkg::G0_LO, jcsc_pkg::G0_HI)));
          n += 2;
        end
        6, 7: begin
          src_bytes_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
          n += 1;
        end
        default: begin
          src_bytes_q.push_back(8'($urandom_range(0, 255)));
          n += 1;
        end
      endcase
    end else if (m <= jcsc_pkg::MODE_SJIS_EUC) begin
      if (sel <= 5) begin
        src_bytes_q.push_back(8'($urandom_range(8'h80, 8'hff)));
        src_bytes_q.push_back(8'($urandom_range(0, 255)));
        n += 2;
      end else if (sel <= 8) begin
        src_bytes_q.push_back(8'($urandom_range(0, 8'h7f)));
        n += 1;
      end else begin
        src_bytes_q.push_back(8'($urandom_range(0, 255)));
        n += 1;
      end
    end else begin
      src_bytes_q.push_back(8'($urandom_range(0, 255)));
      n += 1;
    end
  endtask

  // Stimulus
  initial begin
    int n;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    out_stall   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = jcsc_pkg::MODE_JIS_SJIS;
    cnv_mode    = jcsc_pkg::MODE_JIS_SJIS;
    cnv_st      = '0;
    src_gap     = 0;
    snk_gap     = 0;
    quiet       = 1'b0;
    err_cnt     = 0;
    sent_cnt    = 0;
    recv_cnt    = 0;
    phase_modes = '{jcsc_pkg::MODE_SJIS_EUC, jcsc_pkg::MODE_JIS_SJIS, jcsc_pkg::MODE_JIS_EUC,
                    jcsc_pkg::MODE_SJIS_JIS, jcsc_pkg::MODE_EUC_JIS, jcsc_pkg::MODE_EUC_SJIS,
                    MODE_PASS_7, MODE_PASS_6, jcsc_pkg::MODE_JIS_EUC};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // JIS in, reset mode: enter kanji, pairs, leave, unknown escape, extremes
    src_bytes_q.push_back(8'h41);
    src_bytes_q.push_back(jcsc_pkg::ESC_CHAR);
    src_bytes_q.push_back(jcsc_pkg::DOLLAR_CODE);
    src_bytes_q.push_back(ASCII_B);
    src_bytes_q.push_back(jcsc_pkg::G0_LO);
    src_bytes_q.push_back(jcsc_pkg::G0_LO);
    src_bytes_q.push_back(jcsc_pkg::G0_HI);
    src_bytes_q.push_back(8'hff);
    src_bytes_q.push_back(jcsc_pkg::ESC_CHAR);
    src_bytes_q.push_back(jcsc_pkg::LPAREN_CODE);
    src_bytes_q.push_back(jcsc_pkg::J_CODE);
    src_bytes_q.push_back(jcsc_pkg::ESC_CHAR);
    src_bytes_q.push_back(8'h58);
    src_bytes_q.push_back(8'h00);
    src_bytes_q.push_back(8'h80);
    drain_and_settle();

    // Shift-JIS to JIS: longest burst, shift back, then leave a lead held
    write_mode(jcsc_pkg::MODE_SJIS_JIS);
    src_bytes_q.push_back(8'h81);
    src_bytes_q.push_back(8'h40);
    src_bytes_q.push_back(8'h41);
    src_bytes_q.push_back(8'he0);
    drain_and_settle();

    // Pass-through mode leaves the held lead alone
    write_mode(MODE_PASS_7);
    src_bytes_q.push_back(8'h55);
    src_bytes_q.push_back(8'haa);
    drain_and_settle();

    // Held lead now pairs under EUC to Shift-JIS
    write_mode(jcsc_pkg::MODE_EUC_SJIS);
    src_bytes_q.push_back(8'hfc);
    drain_and_settle();

    // Random phases over every mode value
    for (int p = 0; p < 9; p++) begin
      if (p == 8) quiet = 1'b1;
      write_mode(phase_modes[p]);
      n = 0;
      while (n < PHASE_BYTES) begin
        queue_fragment(phase_modes[p], n);
        // in phase 3 the source holds off mid-phase until everything owed has come back
        if (p == 3 && n >= PHASE_BYTES / 2 && n < PHASE_BYTES / 2 + 3) begin
          drain_and_settle();
        end
      end
      drain_and_settle();
    end

    if (owed_bytes_q.size() != 0) begin
      flag_error($sformatf("%0d result bytes never arrived", owed_bytes_q.size()));
    end
    $display("Sent %0d source bytes and checked %0d result bytes across mode values 0..7,",
             sent_cnt, recv_cnt);
    $display("including escapes, kanji pairs, shift bursts and state kept over mode changes.");
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Mismatches: %0d", err_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout: source or result channel hung");
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== japanese_charset_stream_converter.f =====
sv/jcsc_pkg.sv
sv/jcsc_decode.sv
sv/jcsc_burst.sv
sv/japanese_charset_stream_converter.sv
verif/tb_japanese_charset_stream_converter.sv
